// ----- src/ufifo_pkg.sv -----
// Shared types and constants for the unique FIFO task list.
// Operation and status codes, word layouts, controller/datapath interface structs.
// No dependencies.
`default_nettype none

package ufifo_pkg;

    localparam int UFIFO_DEPTH = 16;

    localparam int KIND_W   = 3;
    localparam int HANDLE_W = 16;
    localparam int KEY_W    = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // s_axis_tdata: handle, key. m_axis_tdata: handle_out, entry_count, list_empty, pad.
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 24;
    localparam int M_PAD_W  = M_DATA_W - HANDLE_W - COUNT_W - 1;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUT    = 3'd0,
        KIND_POP    = 3'd1,
        KIND_REMOVE = 3'd2,
        KIND_FIND   = 3'd3,
        KIND_READ   = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_DUP  = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        POS_HOLD = 2'd0,
        POS_ZERO = 2'd1,
        POS_KEY  = 2'd2,
        POS_INC  = 2'd3
    } pos_op_t;

    // controller -> datapath
    typedef struct packed {
        logic    load;       // latch incoming word, clear result
        pos_op_t pos_op;     // scan pointer update
        logic    wr_shift;   // move entry at pointer down by one
        logic    wr_append;  // write new entry at the tail
        logic    res_cap;    // capture handle read at pointer
        logic    st_set;     // override status
        status_t st_code;
        logic    fill_inc;
        logic    fill_dec;
        logic    out_load;   // move result into output register
    } ufifo_cmd_t;

    // datapath -> controller
    typedef struct packed {
        kind_t kind;
        logic  at_end;    // pointer past the last occupied entry
        logic  match;     // entry at pointer matches handle or id
        logic  empty;
        logic  full;
        logic  key_ok;    // read-at position inside the list
        logic  out_free;  // output register can take a word
    } ufifo_stat_t;

endpackage

`default_nettype wire

// ----- src/ufifo_dp.sv -----
// Datapath of the unique FIFO task list: entry memories, fill count, scan pointer,
// result and output registers. Driven by ufifo_ctrl; uses ufifo_pkg.
`default_nettype none

module ufifo_dp #(
    parameter int DEPTH = ufifo_pkg::UFIFO_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ufifo_pkg::ufifo_cmd_t         cmd,
    output ufifo_pkg::ufifo_stat_t        stat,
    input  logic [ufifo_pkg::S_DATA_W-1:0] s_axis_tdata,
    input  logic [ufifo_pkg::KIND_W-1:0]   s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ufifo_pkg::M_DATA_W-1:0] m_axis_tdata,
    output logic [ufifo_pkg::STATUS_W-1:0] m_axis_tuser
);
    import ufifo_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [HANDLE_W-1:0] hmem [DEPTH];
    logic [KEY_W-1:0]    imem [DEPTH];

    logic [HANDLE_W-1:0] hrd_reg;
    logic [KEY_W-1:0]    ird_reg;

    kind_t               kind_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [KEY_W-1:0]    key_reg;
    status_t             st_reg;
    logic [HANDLE_W-1:0] res_reg;

    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic          m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    status_t       m_user_reg;

    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [CW-1:0] pos_prev;
    logic          wr_en;
    logic [HANDLE_W-1:0] wr_handle;
    logic [KEY_W-1:0]    wr_key;

    // pointer; read address follows it so read data always belongs to pos_reg
    always_comb begin
        case (cmd.pos_op)
            POS_HOLD: pos_next = pos_reg;
            POS_ZERO: pos_next = '0;
            POS_KEY:  pos_next = CW'(s_axis_tdata[HANDLE_W +: KEY_W]);
            POS_INC:  pos_next = pos_reg + CW'(1);
            default:  pos_next = pos_reg;
        endcase
    end

    always_comb begin
        fill_next = fill_reg;
        if (cmd.fill_inc) begin
            fill_next = fill_reg + CW'(1);
        end else if (cmd.fill_dec) begin
            fill_next = fill_reg - CW'(1);
        end
    end

    assign rd_addr  = pos_next[AW-1:0];
    assign pos_prev = pos_reg - CW'(1);

    always_comb begin
        wr_en     = cmd.wr_shift | cmd.wr_append;
        wr_addr   = cmd.wr_shift ? pos_prev[AW-1:0] : fill_reg[AW-1:0];
        wr_handle = cmd.wr_shift ? hrd_reg : handle_reg;
        wr_key    = cmd.wr_shift ? ird_reg : key_reg;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hmem[wr_addr] <= wr_handle;
            imem[wr_addr] <= wr_key;
        end
        hrd_reg <= hmem[rd_addr];
        ird_reg <= imem[rd_addr];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            pos_reg  <= pos_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg   <= kind_t'(s_axis_tuser);
            handle_reg <= s_axis_tdata[0 +: HANDLE_W];
            key_reg    <= s_axis_tdata[HANDLE_W +: KEY_W];
            st_reg     <= ST_OK;
            res_reg    <= '0;
        end else begin
            if (cmd.st_set) begin
                st_reg <= cmd.st_code;
            end
            if (cmd.res_cap) begin
                res_reg <= hrd_reg;
            end
        end
        if (cmd.out_load) begin
            m_data_reg <= {{M_PAD_W{1'b0}}, (fill_reg == '0), COUNT_W'(fill_reg), res_reg};
            m_user_reg <= st_reg;
        end
    end

    always_comb begin
        stat.kind     = kind_reg;
        stat.at_end   = (pos_reg >= fill_reg);
        stat.match    = (kind_reg == KIND_FIND) ? (ird_reg == key_reg)
                                                : (hrd_reg == handle_reg);
        stat.empty    = (fill_reg == '0);
        stat.full     = (fill_reg == CW'(DEPTH));
        stat.key_ok   = (key_reg < KEY_W'(fill_reg));
        stat.out_free = !m_valid_reg || m_axis_tready;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(DEPTH))
        else $error("fill count above depth");
    a_no_inc_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fill_inc |-> !stat.full)
        else $error("append into full list");
    a_no_dec_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fill_dec |-> !stat.empty)
        else $error("removal from empty list");
    a_shift_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_shift |-> (pos_reg != '0 && !stat.at_end))
        else $error("gap close outside occupied entries");
    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(m_valid_reg && !m_axis_tready))
        else $error("pending result word overwritten");
`endif

endmodule

`default_nettype wire

// ----- src/ufifo_ctrl.sv -----
// Controller of the unique FIFO task list: sequences scan, gap close and result.
// Issues ufifo_cmd_t, reads ufifo_stat_t; uses ufifo_pkg.
`default_nettype none

module ufifo_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [ufifo_pkg::KIND_W-1:0] s_axis_tuser,
    input  ufifo_pkg::ufifo_stat_t       stat,
    output ufifo_pkg::ufifo_cmd_t        cmd
);
    import ufifo_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_CHK,
        S_READ_CHK,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    kind_t  kind_in;

    assign kind_in       = kind_t'(s_axis_tuser);
    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        cmd.pos_op = POS_HOLD;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd.load   = 1'b1;
                    cmd.pos_op = (kind_in == KIND_READ) ? POS_KEY : POS_ZERO;
                    case (kind_in)
                        KIND_PUT, KIND_REMOVE, KIND_FIND: state_next = S_SCAN;
                        KIND_POP:                          state_next = S_POP_CHK;
                        KIND_READ:                         state_next = S_READ_CHK;
                        default:                           state_next = S_FINISH;
                    endcase
                end
            end
            S_POP_CHK: begin
                if (stat.empty) begin
                    cmd.st_set  = 1'b1;
                    cmd.st_code = ST_MISS;
                    state_next  = S_FINISH;
                end else begin
                    cmd.res_cap = 1'b1;
                    cmd.pos_op  = POS_INC;
                    state_next  = S_SHIFT;
                end
            end
            S_READ_CHK: begin
                if (stat.key_ok) begin
                    cmd.res_cap = 1'b1;
                end else begin
                    cmd.st_set  = 1'b1;
                    cmd.st_code = ST_MISS;
                end
                state_next = S_FINISH;
            end
            S_SCAN: begin
                if (stat.at_end) begin
                    // not found
                    state_next = S_FINISH;
                    if (stat.kind == KIND_PUT) begin
                        if (stat.full) begin
                            cmd.st_set  = 1'b1;
                            cmd.st_code = ST_FULL;
                        end else begin
                            cmd.wr_append = 1'b1;
                            cmd.fill_inc  = 1'b1;
                        end
                    end else begin
                        cmd.st_set  = 1'b1;
                        cmd.st_code = ST_MISS;
                    end
                end else if (stat.match) begin
                    case (stat.kind)
                        KIND_PUT: begin
                            cmd.st_set  = 1'b1;
                            cmd.st_code = ST_DUP;
                            state_next  = S_FINISH;
                        end
                        KIND_REMOVE: begin
                            cmd.pos_op = POS_INC;
                            state_next = S_SHIFT;
                        end
                        KIND_FIND: begin
                            cmd.res_cap = 1'b1;
                            state_next  = S_FINISH;
                        end
                        default: state_next = S_FINISH;
                    endcase
                end else begin
                    cmd.pos_op = POS_INC;
                end
            end
            S_SHIFT: begin
                if (stat.at_end) begin
                    cmd.fill_dec = 1'b1;
                    state_next   = S_FINISH;
                end else begin
                    cmd.wr_shift = 1'b1;
                    cmd.pos_op   = POS_INC;
                end
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/unique_fifo_task_list.sv -----
// Top level of the unique FIFO task list: stream ports, controller and datapath.
// Instantiates ufifo_ctrl and ufifo_dp; uses ufifo_pkg.
`default_nettype none

// An ordered list of up to DEPTH task handles, each stored with a 16-bit task id,
// kept in arrival order. Each input word carries one operation (put, pop oldest,
// remove handle, find by id, read at position) and yields exactly one result word
// with a status, a handle, the entry count and an empty flag. Put refuses a handle
// already present (ids are not compared) and drops the item when full. Removal
// closes the gap so the order is kept. Find returns the oldest id match.
// One operation is in flight at a time. Entries sit in a memory with one read and
// one write port, read one entry per clock. Read-at checks the position and reads
// it; unknown kinds go straight to the result. Put and find scan the entries in
// order; pop shifts every later entry down; remove scans to the match, then shifts
// the rest down. An item waits to finish while the previous result still holds the
// output register against a low m_axis_tready. The output register lets the next
// word be accepted while the last result still waits on m_axis_tready. The memories
// need no clearing after reset; entries beyond the count are never read.

module unique_fifo_task_list #(
    parameter int DEPTH = ufifo_pkg::UFIFO_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [ufifo_pkg::S_DATA_W-1:0] s_axis_tdata,  // [15:0] handle, [31:16] key
    input  logic [ufifo_pkg::KIND_W-1:0]   s_axis_tuser,  // [2:0] kind
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [15:0] handle_out, [20:16] entry_count, [21] list_empty, [23:22] zero
    output logic [ufifo_pkg::M_DATA_W-1:0] m_axis_tdata,
    output logic [ufifo_pkg::STATUS_W-1:0] m_axis_tuser   // [1:0] status
);
    import ufifo_pkg::*;

    ufifo_cmd_t  cmd;
    ufifo_stat_t stat;

    ufifo_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .stat          (stat),
        .cmd           (cmd)
    );

    ufifo_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for unique_fifo_task_list: directed and random list operations.
// Predicts each reply word from a queue-based model of the task list; uses ufifo_pkg.
`timescale 1ns / 1ps

module tb;
    import ufifo_pkg::*;

    localparam int LIST_DEPTH     = UFIFO_DEPTH;
    localparam int RANDOM_OPS     = 1200;
    localparam int STALL_LIMIT    = 2000;  // cycles with no handshake on either side
    localparam int DRAIN_CYCLES   = 40;    // settle time after the last reply
    localparam int HANDLE_POOL_SZ = 24;    // more than DEPTH, so puts can fill the list
    localparam int ID_POOL_SZ     = 8;

    // unused kind codes; the block must answer them without touching the list
    localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_MID   = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    key;
    } op_word_t;

    typedef struct packed {
        status_t             status;
        logic [HANDLE_W-1:0] handle_out;
        logic [COUNT_W-1:0]  count;
        logic                empty;
    } reply_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;   // [15:0] handle, [31:16] key
    logic [KIND_W-1:0]   s_axis_tuser  = '0;   // [2:0] kind
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // [15:0] handle_out, [20:16] entry_count, [21] list_empty, [23:22] zero
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0] m_axis_tuser;          // [1:0] status

    unique_fifo_task_list #(
        .DEPTH(LIST_DEPTH)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Task list model: oldest entry at index 0, same as the block's order.
    // ------------------------------------------------------------------
    logic [HANDLE_W-1:0] list_handles[$];
    logic [KEY_W-1:0]    list_ids[$];

    op_word_t op_words[$];      // words waiting for the driver
    reply_t   list_replies[$];  // predicted replies, oldest first

    logic [HANDLE_W-1:0] handle_pool[HANDLE_POOL_SZ];
    logic [KEY_W-1:0]    id_pool[ID_POOL_SZ];

    int          fails = 0;
    int          real_ops = 0;   // words with a defined kind
    logic [31:0] cyc = '0;
    logic        in_taken = 1'b0;  // input word accepted at the last rising edge
    int          gap_left = 0;
    int          burst_left = 0;
    int          rdy_left = 0;
    int          stall_left = 0;
    int          idle_cycles = 0;

    // Both sides run without idling whenever cyc[11:10] is 2'b11, one quarter of the time.
    wire quiet = (cyc[11:10] == 2'b11);

    function automatic int handle_pos(logic [HANDLE_W-1:0] h);
        int pos;
        pos = -1;
        for (int i = 0; i < list_handles.size() && pos < 0; i++)
            if (list_handles[i] == h) pos = i;
        return pos;
    endfunction

    // Apply one operation to the model and return the reply it should produce.
    function automatic reply_t list_apply(logic [KIND_W-1:0] kind, logic [HANDLE_W-1:0] h,
                                          logic [KEY_W-1:0] key);
        reply_t r;
        int     pos;
        r.status     = ST_OK;
        r.handle_out = '0;
        case (kind)
            KIND_PUT: begin
                // duplicate check looks at handles only, not ids
                if (handle_pos(h) >= 0) begin
                    r.status = ST_DUP;
                end else if (list_handles.size() >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    list_handles.push_back(h);
                    list_ids.push_back(key);
                end
            end
            KIND_POP: begin
                if (list_handles.size() == 0) begin
                    r.status = ST_MISS;
                end else begin
                    r.handle_out = list_handles.pop_front();
                    void'(list_ids.pop_front());
                end
            end
            KIND_REMOVE: begin
                pos = handle_pos(h);
                if (pos >= 0) begin
                    list_handles.delete(pos);
                    list_ids.delete(pos);
                end else begin
                    r.status = ST_MISS;
                end
            end
            KIND_FIND: begin
                // oldest matching id wins
                r.status = ST_MISS;
                for (int i = 0; i < list_ids.size() && r.status == ST_MISS; i++) begin
                    if (list_ids[i] == key) begin
                        r.status     = ST_OK;
                        r.handle_out = list_handles[i];
                    end
                end
            end
            KIND_READ: begin
                if (int'(key) < list_handles.size()) r.handle_out = list_handles[key];
                else r.status = ST_MISS;
            end
            default: ;
        endcase
        r.count = COUNT_W'(list_handles.size());
        r.empty = (list_handles.size() == 0);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void add_op(logic [KIND_W-1:0] kind, logic [HANDLE_W-1:0] h,
                                   logic [KEY_W-1:0] key);
        op_word_t w;
        w.kind   = kind;
        w.handle = h;
        w.key    = key;
        op_words.push_back(w);
        if (kind <= KIND_READ) real_ops++;
    endfunction

    // Any 16-bit value.
    function automatic logic [HANDLE_W-1:0] rnd16();
        return HANDLE_W'($urandom);
    endfunction

    // Mostly pool handles so removes and duplicates hit; now and then anything.
    function automatic logic [HANDLE_W-1:0] pick_handle();
        if ($urandom_range(0, 15) == 0) return rnd16();
        return handle_pool[$urandom_range(0, HANDLE_POOL_SZ - 1)];
    endfunction

    function automatic logic [KEY_W-1:0] pick_id();
        if ($urandom_range(0, 7) == 0) return KEY_W'($urandom);
        return id_pool[$urandom_range(0, ID_POOL_SZ - 1)];
    endfunction

    // Positions around the live range, plus the odd wild one.
    function automatic logic [KEY_W-1:0] pick_pos();
        if ($urandom_range(0, 9) == 0) return KEY_W'($urandom);
        return KEY_W'($urandom_range(0, LIST_DEPTH + 1));
    endfunction

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int n;
        handle_pool[0] = '0;
        handle_pool[1] = '1;
        for (int i = 2; i < HANDLE_POOL_SZ; i++) handle_pool[i] = rnd16();
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < ID_POOL_SZ; i++) id_pool[i] = KEY_W'($urandom);

        // directed: empty list corner cases first
        add_op(KIND_POP,    16'h0000, 16'h0000);
        add_op(KIND_FIND,   16'h0000, 16'h0000);
        add_op(KIND_READ,   16'h0000, 16'h0000);
        add_op(KIND_REMOVE, 16'h0000, 16'h0000);
        add_op(KIND_SPARE_FIRST, 16'hFFFF, 16'hFFFF);
        // handle zero is a normal handle; second put of it is a duplicate
        add_op(KIND_PUT,    16'h0000, 16'hFFFF);
        add_op(KIND_PUT,    16'h0000, 16'h0001);
        add_op(KIND_PUT,    16'hFFFF, 16'h0000);
        add_op(KIND_PUT,    16'h1234, 16'h0000);
        // two entries share id 0: find must return the older one
        add_op(KIND_FIND,   16'h0000, 16'h0000);
        add_op(KIND_FIND,   16'h0000, 16'h0007);
        add_op(KIND_READ,   16'h0000, 16'h0002);
        add_op(KIND_READ,   16'h0000, 16'h0003);   // one past the end
        add_op(KIND_READ,   16'h0000, 16'hFFFF);
        // remove from the middle, then check the gap closed
        add_op(KIND_REMOVE, 16'hFFFF, 16'h0000);
        add_op(KIND_READ,   16'h0000, 16'h0001);
        add_op(KIND_REMOVE, 16'h5555, 16'h0000);
        add_op(KIND_SPARE_MID, 16'h0000, 16'h0000);
        add_op(KIND_SPARE_LAST, 16'hAAAA, 16'h5555);
        add_op(KIND_POP,    16'h0000, 16'h0000);
        add_op(KIND_POP,    16'h0000, 16'h0000);
        add_op(KIND_POP,    16'h0000, 16'h0000);

        // random runs: fill, drain, query, mixed and noise
        real_ops = 0;
        while (real_ops < RANDOM_OPS) begin
            n = $urandom_range(6, 20);
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    repeat (n) add_op(KIND_PUT, pick_handle(), pick_id());
                end
                3, 4, 5: begin
                    repeat (n) begin
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3, 4: add_op(KIND_POP, rnd16(), rnd16());
                            9:             add_op(KIND_REMOVE, rnd16(), rnd16());
                            default:       add_op(KIND_REMOVE, pick_handle(), rnd16());
                        endcase
                    end
                end
                6, 7: begin
                    repeat (n) begin
                        if ($urandom_range(0, 1) != 0) add_op(KIND_FIND, rnd16(), pick_id());
                        else add_op(KIND_READ, rnd16(), pick_pos());
                    end
                end
                8: begin
                    repeat (n) begin
                        case ($urandom_range(0, 4))
                            0: add_op(KIND_PUT, pick_handle(), pick_id());
                            1: add_op(KIND_POP, rnd16(), rnd16());
                            2: add_op(KIND_REMOVE, pick_handle(), rnd16());
                            3: add_op(KIND_FIND, rnd16(), pick_id());
                            default: add_op(KIND_READ, rnd16(), pick_pos());
                        endcase
                    end
                end
                default: begin
                    // fully random words, spare kinds included
                    repeat (n) add_op(KIND_W'($urandom_range(0, KIND_SPARE_LAST)),
                                      rnd16(), rnd16());
                end
            endcase
        end

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // wait for every word to go in and every reply to come back;
        // sampled on the rising edge, where the driver's outputs are settled
        while (op_words.size() != 0 || (s_axis_tvalid && !in_taken) ||
               list_replies.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (fails == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: bursts of words separated by random gaps, launched on the
    // falling edge. A word stays up until the edge that accepts it.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : drv
        op_word_t w;
        if (aresetn && !(s_axis_tvalid && !in_taken)) begin
            if (gap_left != 0 && !quiet) begin
                gap_left = gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (op_words.size() != 0) begin
                w = op_words.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {w.key, w.handle};
                s_axis_tuser  <= w.kind;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 12);
                    case ($urandom_range(0, 3))
                        0, 1:    gap_left = 0;
                        2:       gap_left = $urandom_range(1, 6);
                        default: gap_left = $urandom_range(7, 20);
                    endcase
                end else begin
                    burst_left = burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver back-pressure: ready runs and stall runs of random length,
    // now and then a long stall so the output register has to hold.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (quiet) begin
            m_axis_tready <= 1'b1;
        end else if (rdy_left != 0) begin
            rdy_left = rdy_left - 1;
            m_axis_tready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            rdy_left   = $urandom_range(0, 10);
            stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 24)
                                                     : $urandom_range(0, 3);
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each accepted input word, check each accepted
    // reply word against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : mon
        reply_t want;
        cyc      <= cyc + 1;
        in_taken <= aresetn && s_axis_tvalid && s_axis_tready;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                list_replies.push_back(list_apply(s_axis_tuser, s_axis_tdata[15:0],
                                                  s_axis_tdata[31:16]));
            if (m_axis_tvalid && m_axis_tready) begin
                if (list_replies.size() == 0) begin
                    $error("reply word with nothing expected: tdata %h tuser %h",
                           m_axis_tdata, m_axis_tuser);
                    fails++;
                end else begin
                    want = list_replies.pop_front();
                    if (m_axis_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                        fails++;
                    end
                    if (m_axis_tdata[15:0] !== want.handle_out) begin
                        $error("handle_out: expected %h, got %h", want.handle_out,
                               m_axis_tdata[15:0]);
                        fails++;
                    end
                    if (m_axis_tdata[20:16] !== want.count) begin
                        $error("entry_count: expected %0d, got %0d", want.count,
                               m_axis_tdata[20:16]);
                        fails++;
                    end
                    if (m_axis_tdata[21] !== want.empty) begin
                        $error("list_empty: expected %b, got %b", want.empty, m_axis_tdata[21]);
                        fails++;
                    end
                    if (m_axis_tdata[23:22] !== 2'b00) begin
                        $error("pad: expected 0, got %b", m_axis_tdata[23:22]);
                        fails++;
                    end
                end
            end
        end
    end

    // Watchdog: a hung handshake on either side ends the run.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

endmodule
